@@ rtl/modular_inverse_unit_core_defines.svh @@
// Assertion macros shared by the modular inverse unit RTL.
`ifndef MODULAR_INVERSE_UNIT_CORE_DEFINES_SVH
`define MODULAR_INVERSE_UNIT_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset
`define MIU_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset
`define MIU_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define MIU_ASSERT_NOW(lbl, ant, cons, msg)
`define MIU_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

@@ rtl/miu_pkg.sv @@
// Shared types for the modular inverse unit.
package miu_pkg;

	// Sequencer states of the Euclid engine
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_ALIGN,
		ST_SUB,
		ST_FINISH
	} miu_state_t;

	// Control from the top level into the engine
	typedef struct packed {
		logic start;
		logic res_ready;
	} miu_ctrl_t;

	// Status from the engine back to the top level
	typedef struct packed {
		logic idle;
		logic res_valid;
		logic has_inverse;
	} miu_stat_t;

endpackage

@@ rtl/miu_if.sv @@
// Valid/ready channel interfaces of the modular inverse unit.
interface miu_req_if #(parameter int WIDTH = 32);
	logic             valid;
	logic             ready;
	logic [WIDTH-2:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface miu_rsp_if #(parameter int WIDTH = 32);
	logic             valid;
	logic             ready;
	logic [WIDTH-2:0] inverse;
	logic             has_inverse;
	modport source (output valid, output inverse, output has_inverse, input ready);
	modport sink (input valid, input inverse, input has_inverse, output ready);
endinterface

interface miu_cfg_if #(parameter int WIDTH = 32);
	logic             valid;
	logic             ready;
	logic [WIDTH-2:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/miu_engine.sv @@
// Shift-subtract extended Euclid engine: serial reduction, then quotient bit by bit.
module miu_engine #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  miu_pkg::miu_ctrl_t ctrl,
	input  logic [WIDTH-2:0]   value,
	input  logic [WIDTH-2:0]   modulus,
	output miu_pkg::miu_stat_t stat,
	output logic [WIDTH-2:0]   inverse
);
	import miu_pkg::*;

	localparam int N  = WIDTH - 1;
	localparam int JW = $clog2(N);
	localparam logic [JW-1:0] CNT_LAST = JW'(N - 1);

	miu_state_t       state_q, state_d;
	logic [N-1:0]     a_q, b_q, d_q;
	logic [WIDTH-1:0] yp_q, yc_q, t_q;
	logic [JW-1:0]    cnt_q;

	logic [N:0]       rem_sh;
	logic             rem_ge;
	logic [N-1:0]     rem_nx;
	logic [N:0]       d_dbl;
	logic             grow;
	logic             sub_ge;
	logic [N-1:0]     a_sub;
	logic [WIDTH-1:0] t_nx;
	logic [WIDTH-1:0] y_fix;
	logic             has_inv;

	// Reduction step: shift one bit of the value into the remainder
	assign rem_sh = {b_q, a_q[N-1]};
	assign rem_ge = rem_sh >= {1'b0, modulus};
	assign rem_nx = rem_ge ? N'(rem_sh - {1'b0, modulus}) : rem_sh[N-1:0];

	// Alignment: double the divisor while it still fits under the dividend
	assign d_dbl = {d_q, 1'b0};
	assign grow  = !d_q[N-1] && (d_dbl <= {1'b0, a_q});

	// Division step: one quotient bit, Horner accumulation of q * y
	assign sub_ge = a_q >= d_q;
	assign a_sub  = sub_ge ? a_q - d_q : a_q;
	assign t_nx   = {t_q[WIDTH-2:0], 1'b0} + (sub_ge ? yc_q : '0);

	// Fold a negative coefficient into range and qualify the result
	assign y_fix   = yp_q[WIDTH-1] ? yp_q + WIDTH'(modulus) : yp_q;
	assign has_inv = (a_q == N'(1)) && (modulus[N-1:1] != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (cnt_q == '0) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (b_q == '0) ? ST_FINISH : ST_ALIGN;
			end
			ST_ALIGN: begin
				if (!grow) state_d = ST_SUB;
			end
			ST_SUB: begin
				if (cnt_q == '0) state_d = ST_CHECK;
			end
			ST_FINISH: begin
				if (ctrl.res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		stat.idle        = 1'b0;
		stat.res_valid   = 1'b0;
		stat.has_inverse = has_inv;
		inverse          = has_inv ? y_fix[N-1:0] : '0;
		case (state_q)
			ST_IDLE: begin
				stat.idle = 1'b1;
			end
			ST_FINISH: begin
				stat.res_valid = 1'b1;
			end
			default: begin
				stat.idle      = 1'b0;
				stat.res_valid = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// load the value into the shift register, clear the remainder
				if (ctrl.start) begin
					a_q   <= value;
					b_q   <= '0;
					cnt_q <= CNT_LAST;
				end
			end
			ST_REDUCE: begin
				b_q <= rem_nx;
				if (cnt_q == '0) begin
					a_q  <= modulus;
					yp_q <= '0;
					yc_q <= WIDTH'(1);
				end else begin
					a_q   <= {a_q[N-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_CHECK: begin
				d_q   <= b_q;
				t_q   <= '0;
				cnt_q <= '0;
			end
			ST_ALIGN: begin
				if (grow) begin
					d_q   <= d_dbl[N-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_SUB: begin
				t_q <= t_nx;
				if (cnt_q == '0) begin
					// quotient done: rotate remainders and coefficients
					a_q  <= b_q;
					b_q  <= a_sub;
					yp_q <= yc_q;
					yc_q <= yp_q - t_nx;
				end else begin
					a_q   <= a_sub;
					d_q   <= {1'b0, d_q[N-1:1]};
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
				// hold
			end
		endcase
	end

endmodule

@@ rtl/modular_inverse_unit_core.sv @@
// Top level of the modular inverse unit: channels, modulus register, result register.
//
//  channel  dir  payload                  item moves when
//  req      in   value                    req.valid && req.ready
//  rsp      out  inverse, has_inverse     rsp.valid && rsp.ready
//  cfg      in   data (modulus)           cfg.valid && cfg.ready
//
// One item at a time: serial reduction of the value, then per Euclid quotient q a check
// step plus align and subtract steps over the bits of q, a last check step and
// a hand-over of the result in the finish state.
// Reset clears the sequencer and the result valid flag and sets the modulus to 2.
// A held result does not block req: the next item is taken while rsp stalls.
`include "modular_inverse_unit_core_defines.svh"

module modular_inverse_unit_core #(
	parameter int WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	miu_req_if.sink    req,
	miu_rsp_if.source  rsp,
	miu_cfg_if.sink    cfg
);
	import miu_pkg::*;

	localparam int N = WIDTH - 1;

	logic [N-1:0] modulus_q;
	miu_ctrl_t    ctrl;
	miu_stat_t    stat;
	logic [N-1:0] eng_inverse;
	logic         rsp_valid_q;
	logic [N-1:0] inverse_q;
	logic         has_inverse_q;

	// Modulus register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= N'(2);
		end else if (cfg.valid && cfg.ready) begin
			modulus_q <= cfg.data;
		end
	end

	// Engine handshakes
	assign req.ready      = stat.idle;
	assign ctrl.start     = req.valid && req.ready;
	assign ctrl.res_ready = !rsp_valid_q || rsp.ready;

	miu_engine #(
		.WIDTH (WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.value   (req.value),
		.modulus (modulus_q),
		.stat    (stat),
		.inverse (eng_inverse)
	);

	// Result register: load when free or being drained, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.res_ready) begin
			rsp_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_ready && stat.res_valid) begin
			inverse_q     <= eng_inverse;
			has_inverse_q <= stat.has_inverse;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.inverse     = inverse_q;
	assign rsp.has_inverse = has_inverse_q;

	// Checks
	`MIU_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !stat.idle, "engine idle after accept")
	`MIU_ASSERT_NOW(a_zero_when_none, rsp.valid && !rsp.has_inverse, rsp.inverse == '0, "nonzero inverse without flag")
	`MIU_ASSERT_NOW(a_nonzero_when_found, rsp.valid && rsp.has_inverse, rsp.inverse != '0, "flagged inverse is zero")

endmodule
